@@ design/assert_macros.svh @@
// Assertion helpers shared by the decoder modules.
// Each expects i_clk and i_rst_n in the scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked out of reset.
`define RSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Overlapping implication, checked out of reset.
`define RSD_ASSERT_IMPL(label, ante, cons, msg) \
    `RSD_ASSERT(label, (ante) |-> (cons), msg)

`endif

@@ design/rsd_pkg.sv @@
package rsd_pkg;

    localparam int DIM_BITS_DEF = 16;

    localparam logic [7:0]  CODE_END      = 8'd255;
    localparam logic [7:0]  CODE_ROW      = 8'd254;
    // header: width (4), height (4), then 8 ignored bytes
    localparam logic [3:0]  HDR_SIZE_BYTE = 4'd7;
    localparam logic [3:0]  HDR_LAST      = 4'd15;
    localparam logic [16:0] POS_MAX       = 17'h1FFFF;
    localparam int          MAX_RESULTS   = 3;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_HDR,
        PH_CODE,
        PH_COUNT,
        PH_PIX,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        KIND_HEADER       = 3'd0,
        KIND_RUN          = 3'd1,
        KIND_PIXEL        = 3'd2,
        KIND_FILL         = 3'd3,
        KIND_END          = 3'd4,
        KIND_BAD_SIZE     = 3'd5,
        KIND_OUT_OF_RANGE = 3'd6
    } t_kind;

    typedef struct packed {
        logic        valid;
        logic [7:0]  data_byte;
        logic        record_start;
    } t_in_beat;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] col;
        logic [15:0] row;
        logic [15:0] run_length;
        logic [7:0]  color_index;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0]                    cnt;
        t_result [MAX_RESULTS-1:0]     res;
    } t_res_set;

    function automatic logic [15:0] sat16_17(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] sat16_18(input logic [17:0] v);
        return (|v[17:16]) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] sat16_32(input logic [31:0] v);
        return (|v[31:16]) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [16:0] sat_pos(input logic [17:0] v);
        return v[17] ? POS_MAX : v[16:0];
    endfunction

    function automatic t_result mk_result(input t_kind kind, input logic [15:0] col,
                                          input logic [15:0] row, input logic [15:0] len,
                                          input logic [7:0] color, input logic [15:0] w,
                                          input logic [15:0] h);
        t_result r;
        r.kind         = kind;
        r.col          = col;
        r.row          = row;
        r.run_length   = len;
        r.color_index  = color;
        r.image_width  = w;
        r.image_height = h;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

@@ design/rsd_in_if.sv @@
interface rsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       record_start;

    modport source (output valid, output data_byte, output record_start, input ready);
    modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

@@ design/rsd_out_if.sv @@
interface rsd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [15:0] col;
    logic [15:0] row;
    logic [15:0] run_length;
    logic [7:0]  color_index;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last;

    modport source (output valid, output result_kind, output col, output row,
                    output run_length, output color_index, output image_width,
                    output image_height, output last, input ready);
    modport sink   (input valid, input result_kind, input col, input row,
                    input run_length, input color_index, input image_width,
                    input image_height, input last, output ready);
endinterface

@@ design/rle_sprite_run_decoder.sv @@
// Run-length sprite record decoder.
// Input channel i_in carries one record byte per beat; record_start marks
// the first byte of a record and restarts header parsing on that byte.
// Output channel o_out carries run descriptors: header, transparent run,
// colour pixel, rows fill, end, bad size and out-of-range, each with its
// coordinates; last marks the final descriptor caused by one input byte.
// A byte accepted into the input register is decoded combinationally and
// its descriptors are loaded into the output register for o_out.
// Throughput: one byte per cycle while each byte gives at most one
// descriptor and the receiver does not stall; a byte with several (row end,
// image end) holds the input until the output register has handed them on.
// A new byte is taken while a descriptor waits, as long as the decoder
// stage can hand its results on in the same cycle.
// Reset clears the decoder to wait for a record start; bytes before one are
// dropped. When the receiver stalls, descriptors hold on o_out and the input
// stalls one byte later.
module rle_sprite_run_decoder #(
    parameter int DIM_BITS = rsd_pkg::DIM_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsd_in_if.sink      i_in,
    rsd_out_if.source   o_out
);
    import rsd_pkg::*;

    t_in_beat beat;
    t_res_set set;
    logic     free;
    logic     advance;

    // byte leaves the input register once its descriptors have a place
    assign advance = beat.valid && ((set.cnt == 2'd0) || free);

    rsd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_beat    (beat)
    );

    rsd_decode #(
        .DIM_BITS (DIM_BITS)
    ) u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (beat),
        .i_advance (advance),
        .o_set     (set)
    );

    rsd_out_seq u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_set     (set),
        .i_advance (advance),
        .o_free    (free),
        .o_out     (o_out)
    );

endmodule

@@ design/rsd_in_stage.sv @@
`include "assert_macros.svh"

module rsd_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rsd_in_if.sink             i_in,
    input  logic               i_advance,
    output rsd_pkg::t_in_beat  o_beat
);
    import rsd_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_start;
    logic       accept;

    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte  <= i_in.data_byte;
            r_start <= i_in.record_start;
        end
    end

    assign o_beat = '{valid: r_valid, data_byte: r_byte, record_start: r_start};

    // the decoder only ever consumes a beat that is held here
    `RSD_ASSERT_IMPL(a_advance_held, i_advance, r_valid, "advance without a held beat")

endmodule

@@ design/rsd_decode.sv @@
`include "assert_macros.svh"

module rsd_decode #(
    parameter int DIM_BITS = rsd_pkg::DIM_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsd_pkg::t_in_beat  i_beat,
    input  logic               i_advance,
    output rsd_pkg::t_res_set  o_set
);
    import rsd_pkg::*;

    t_phase      r_phase,   n_phase,   e_phase;
    logic [3:0]  r_hdr_cnt, n_hdr_cnt, e_hdr_cnt;
    logic [31:0] r_width,   n_width,   e_width;
    logic [31:0] r_height,  n_height,  e_height;
    logic [16:0] r_col,     n_col,     e_col;
    logic [16:0] r_row,     n_row,     e_row;
    logic [7:0]  r_left,    n_left,    e_left;

    logic [7:0]  b;
    logic        size_bad;
    logic        row_in;
    logic [17:0] col_run;
    logic [17:0] col_pix;
    logic [17:0] first_row;
    logic [31:0] acc_width;
    logic [31:0] acc_height;

    t_result [MAX_RESULTS-1:0] res;
    logic [1:0]                cnt;

    function automatic logic is_bad(input logic [31:0] v);
        return (v == '0) || v[31] || ((v >> DIM_BITS) != '0);
    endfunction

    assign b = i_beat.data_byte;

    // record start restarts parsing with this byte as header byte 0
    always_comb begin
        if (i_beat.record_start) begin
            e_phase   = PH_HDR;
            e_hdr_cnt = '0;
            e_width   = '0;
            e_height  = '0;
            e_col     = '0;
            e_row     = '0;
            e_left    = '0;
        end else begin
            e_phase   = r_phase;
            e_hdr_cnt = r_hdr_cnt;
            e_width   = r_width;
            e_height  = r_height;
            e_col     = r_col;
            e_row     = r_row;
            e_left    = r_left;
        end
    end

    // header bytes 0-3 carry the width, 4-7 the height
    always_comb begin
        acc_width  = e_width;
        acc_height = e_height;
        if (!e_hdr_cnt[3] && !e_hdr_cnt[2]) begin
            acc_width = e_width | (32'(b) << {e_hdr_cnt[1:0], 3'b000});
        end else if (!e_hdr_cnt[3]) begin
            acc_height = e_height | (32'(b) << {e_hdr_cnt[1:0], 3'b000});
        end
    end

    assign col_run   = {1'b0, e_col} + {10'b0, b};
    assign col_pix   = {1'b0, e_col} + 18'd1;
    assign first_row = {1'b0, e_row} + 18'd1;
    assign row_in    = {15'b0, e_row} < e_height;
    assign size_bad  = is_bad(acc_width) || is_bad(acc_height);

    // next state
    always_comb begin
        n_phase   = e_phase;
        n_hdr_cnt = e_hdr_cnt;
        n_width   = e_width;
        n_height  = e_height;
        n_col     = e_col;
        n_row     = e_row;
        n_left    = e_left;
        case (e_phase)
            PH_HDR: begin
                n_width  = acc_width;
                n_height = acc_height;
                if (e_hdr_cnt == HDR_SIZE_BYTE && size_bad) begin
                    n_phase = PH_DONE;
                end else if (e_hdr_cnt == HDR_LAST) begin
                    n_hdr_cnt = '0;
                    n_phase   = PH_CODE;
                end else begin
                    n_hdr_cnt = e_hdr_cnt + 4'd1;
                end
            end
            PH_CODE: begin
                if (b == CODE_END) begin
                    n_phase = PH_DONE;
                end else if (b == CODE_ROW) begin
                    n_col = '0;
                    n_row = sat_pos(first_row);
                end else begin
                    n_col   = sat_pos(col_run);
                    n_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                n_left  = b;
                n_phase = (b == 8'd0) ? PH_CODE : PH_PIX;
            end
            PH_PIX: begin
                n_col  = sat_pos(col_pix);
                n_left = e_left - 8'd1;
                if (n_left == 8'd0) begin
                    n_phase = PH_CODE;
                end
            end
            default: ;
        endcase
    end

    // result descriptors for this byte, packed from slot 0
    always_comb begin
        logic [1:0] idx;
        idx = '0;
        res = '0;
        case (e_phase)
            PH_HDR: begin
                if (e_hdr_cnt == HDR_SIZE_BYTE) begin
                    res[0] = mk_result(size_bad ? KIND_BAD_SIZE : KIND_HEADER, '0, '0, '0,
                                       '0, sat16_32(acc_width), sat16_32(acc_height));
                    idx    = 2'd1;
                end
            end
            PH_CODE: begin
                if (b inside {CODE_END, CODE_ROW}) begin
                    // rest of the current row
                    if ({15'b0, e_col} < e_width) begin
                        res[idx] = mk_result(row_in ? KIND_RUN : KIND_OUT_OF_RANGE,
                                             sat16_17(e_col), sat16_17(e_row),
                                             sat16_32(e_width - {15'b0, e_col}),
                                             '0, '0, '0);
                        idx      = idx + 2'd1;
                    end
                    if (b == CODE_END) begin
                        if ({14'b0, first_row} < e_height) begin
                            res[idx] = mk_result(KIND_FILL, '0, sat16_18(first_row),
                                                 sat16_32(e_height - {14'b0, first_row}),
                                                 '0, '0, '0);
                            idx      = idx + 2'd1;
                        end
                        res[idx] = mk_result(KIND_END, '0, '0, '0, '0, '0, '0);
                        idx      = idx + 2'd1;
                    end
                end else if (b != 8'd0) begin
                    res[0] = mk_result((row_in && ({14'b0, col_run} <= e_width)) ?
                                       KIND_RUN : KIND_OUT_OF_RANGE,
                                       sat16_17(e_col), sat16_17(e_row), {8'b0, b},
                                       '0, '0, '0);
                    idx    = 2'd1;
                end
            end
            PH_PIX: begin
                res[0] = mk_result((row_in && ({14'b0, col_pix} <= e_width)) ?
                                   KIND_PIXEL : KIND_OUT_OF_RANGE,
                                   sat16_17(e_col), sat16_17(e_row), 16'd1, b, '0, '0);
                idx    = 2'd1;
            end
            default: ;
        endcase
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i].last = ((2'(i) + 2'd1) == idx);
        end
        cnt = idx;
    end

    assign o_set = '{cnt: cnt, res: res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT;
            r_hdr_cnt <= '0;
            r_width   <= '0;
            r_height  <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_left    <= '0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_width   <= n_width;
            r_height  <= n_height;
            r_col     <= n_col;
            r_row     <= n_row;
            r_left    <= n_left;
        end
    end

    // a pixel phase always has pixels still to come
    `RSD_ASSERT_IMPL(a_pix_left, r_phase == PH_PIX, r_left != 8'd0, "pixel phase with no pixels")
    // idle or finished record: bytes give nothing
    `RSD_ASSERT_IMPL(a_idle_silent,
        i_beat.valid && !i_beat.record_start && (r_phase == PH_DONE || r_phase == PH_WAIT),
        o_set.cnt == 2'd0, "result from an idle record")

endmodule

@@ design/rsd_out_seq.sv @@
`include "assert_macros.svh"

module rsd_out_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsd_pkg::t_res_set  i_set,
    input  logic               i_advance,
    output logic               o_free,
    rsd_out_if.source          o_out
);
    import rsd_pkg::*;

    t_result [MAX_RESULTS-1:0] r_res;
    logic [1:0]                r_cnt;
    logic                      load;
    logic                      pop;

    assign load   = i_advance && (i_set.cnt != 2'd0);
    assign pop    = (r_cnt != 2'd0) && o_out.ready;
    // free when empty or when the final pending beat leaves this cycle
    assign o_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= i_set.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // advance the queue one slot per beat taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_set.res;
        end else if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                r_res[i] <= r_res[i+1];
            end
        end
    end

    assign o_out.valid        = r_cnt != 2'd0;
    assign o_out.result_kind  = r_res[0].kind;
    assign o_out.col          = r_res[0].col;
    assign o_out.row          = r_res[0].row;
    assign o_out.run_length   = r_res[0].run_length;
    assign o_out.color_index  = r_res[0].color_index;
    assign o_out.image_width  = r_res[0].image_width;
    assign o_out.image_height = r_res[0].image_height;
    assign o_out.last         = r_res[0].last;

    `RSD_ASSERT_IMPL(a_load_free, load, o_free, "result set loaded over pending beats")
    `RSD_ASSERT_IMPL(a_last_tail, o_out.valid, o_out.last == (r_cnt == 2'd1),
        "last flag out of step with pending count")

endmodule
